FILE: rtl/ntc_sample_smoother_defines.svh
// assertion macros shared by the thermistor smoother rtl
// needs i_clk and i_rst_n in scope at the point of use
`ifndef NTC_SAMPLE_SMOOTHER_DEFINES_SVH
`define NTC_SAMPLE_SMOOTHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define NSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/nss_pkg.sv
// shared widths, curve coefficients and types for the thermistor smoother
// no dependencies
package nss_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int PRESCALE_SHIFT = 3;
    localparam int LEVEL_BITS     = SAMPLE_BITS - PRESCALE_SHIFT;
    localparam int FRACTION_BITS  = 16;
    localparam int STATE_BITS     = LEVEL_BITS + FRACTION_BITS;
    localparam int ALPHA_BITS     = 16;
    localparam int TEMP_BITS      = 8;

    // shared multiplier operands and product
    localparam int OPA_BITS  = STATE_BITS + 1;
    localparam int OPB_BITS  = ALPHA_BITS + 2;
    localparam int PROD_BITS = OPA_BITS + OPB_BITS;

    // curve arithmetic, signed q.16
    localparam int CURVE_FRAC = 16;
    localparam int CURVE_BITS = 27;
    localparam int SLOPE_BITS = 16;
    localparam int OFFS_BITS  = 25;

    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(64225);

    localparam logic [LEVEL_BITS-1:0] CURVE_TOP    = LEVEL_BITS'(498);
    localparam logic [LEVEL_BITS-1:0] CURVE_B20    = LEVEL_BITS'(476);
    localparam logic [LEVEL_BITS-1:0] CURVE_B40    = LEVEL_BITS'(435);
    localparam logic [LEVEL_BITS-1:0] CURVE_B60    = LEVEL_BITS'(371);
    localparam logic [LEVEL_BITS-1:0] CURVE_B100   = LEVEL_BITS'(208);
    localparam logic [LEVEL_BITS-1:0] CURVE_BOTTOM = LEVEL_BITS'(76);

    localparam logic [SLOPE_BITS-1:0] K1_SLOPE = SLOPE_BITS'(59054);
    localparam logic [OFFS_BITS-1:0]  K1_OFFS  = OFFS_BITS'(29482025);
    localparam logic [SLOPE_BITS-1:0] K2_SLOPE = SLOPE_BITS'(31674);
    localparam logic [OFFS_BITS-1:0]  K2_OFFS  = OFFS_BITS'(16458711);
    localparam logic [SLOPE_BITS-1:0] K3_SLOPE = SLOPE_BITS'(20165);
    localparam logic [OFFS_BITS-1:0]  K3_OFFS  = OFFS_BITS'(11441930);
    localparam logic [SLOPE_BITS-1:0] K4_SLOPE = SLOPE_BITS'(15820);
    localparam logic [OFFS_BITS-1:0]  K4_OFFS  = OFFS_BITS'(9816637);
    localparam logic signed [OPB_BITS-1:0] K5_SQ = OPB_BITS'(79);
    localparam logic [SLOPE_BITS-1:0] K5_SLOPE = SLOPE_BITS'(45954);
    localparam logic [OFFS_BITS-1:0]  K5_OFFS  = OFFS_BITS'(12814909);

    // curve value is (sq * L - slope) * L + offs
    typedef struct packed {
        logic                       on_curve;
        logic signed [OPB_BITS-1:0] sq;
        logic [SLOPE_BITS-1:0]      slope;
        logic [OFFS_BITS-1:0]       offs;
    } t_coef;

endpackage

FILE: rtl/nss_mult.sv
// shared signed multiplier with registered product
// depends on nss_pkg
module nss_mult (
    input  logic                                 i_clk,
    input  logic signed [nss_pkg::OPA_BITS-1:0]  i_op_a,
    input  logic signed [nss_pkg::OPB_BITS-1:0]  i_op_b,
    output logic signed [nss_pkg::PROD_BITS-1:0] o_prod
);
    import nss_pkg::*;

    logic signed [PROD_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_BITS'(i_op_a) * PROD_BITS'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/nss_curve_seg.sv
// segment decode of the ntc curve: picks coefficients for a level
// depends on nss_pkg
module nss_curve_seg (
    input  logic [nss_pkg::LEVEL_BITS-1:0] i_level,
    output nss_pkg::t_coef                 o_coef
);
    import nss_pkg::*;

    always_comb begin
        o_coef.on_curve = (i_level >= CURVE_BOTTOM) && (i_level <= CURVE_TOP);
        o_coef.sq       = '0;
        if (i_level >= CURVE_B20) begin
            o_coef.slope = K1_SLOPE;
            o_coef.offs  = K1_OFFS;
        end else if (i_level >= CURVE_B40) begin
            o_coef.slope = K2_SLOPE;
            o_coef.offs  = K2_OFFS;
        end else if (i_level >= CURVE_B60) begin
            o_coef.slope = K3_SLOPE;
            o_coef.offs  = K3_OFFS;
        end else if (i_level >= CURVE_B100) begin
            o_coef.slope = K4_SLOPE;
            o_coef.offs  = K4_OFFS;
        end else begin
            // quadratic segment at the hot end
            o_coef.sq    = K5_SQ;
            o_coef.slope = K5_SLOPE;
            o_coef.offs  = K5_OFFS;
        end
    end

endmodule

FILE: rtl/ntc_sample_smoother.sv
// top level of the thermistor sample smoother: sequencer, filter state, output register
// depends on nss_pkg, nss_mult, nss_curve_seg and ntc_sample_smoother_defines.svh
//
// input channel: i_in_valid / o_in_stall carry one 12-bit converter reading per item.
// output channel: o_out_valid / i_out_stall carry filtered temp, raw temp and the
// integer filter level. i_cfg_we writes the 16-bit smoothing weight (q0.16); only
// while no item is in flight; the user must keep to this, as the block does not enforce it.
// each item runs on one shared 26x18 multiplier under a small sequencer: one filter
// multiply, one state update, then two multiplies and one add per curve evaluation,
// done for the filtered and the unfiltered level, and a done state that loads the result.
// the states run in the order FILT, UPD, MUL1, MUL2, ADD, MUL1, MUL2, ADD, DONE, and
// o_out_valid is registered as DONE loads the result; a new item is only accepted in
// IDLE, once the previous item has left DONE.
// o_in_stall is high while an item is being worked on.
// reset clears the filter state to zero, the weight to 64225 and drops o_out_valid.
// a stalled result stays on the outputs; the next item is still taken and computed,
// and waits in its load cycle until the pending result has been taken.
`include "ntc_sample_smoother_defines.svh"

module ntc_sample_smoother (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nss_pkg::ALPHA_BITS-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [nss_pkg::SAMPLE_BITS-1:0]      i_adc_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [nss_pkg::TEMP_BITS-1:0]        o_filtered_temp,
    output logic [nss_pkg::TEMP_BITS-1:0]        o_raw_temp,
    output logic [nss_pkg::LEVEL_BITS-1:0]       o_filtered_level
);
    import nss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILT = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam int HI_BITS = PROD_BITS - ALPHA_BITS;

    logic [2:0]                  r_state, n_state;
    logic                        r_sel_raw;
    logic [ALPHA_BITS-1:0]       r_alpha;
    logic [STATE_BITS-1:0]       r_y;
    logic [LEVEL_BITS-1:0]       r_level;
    logic signed [OPA_BITS-1:0]  r_diff;
    logic [TEMP_BITS-1:0]        r_ftemp;
    logic [TEMP_BITS-1:0]        r_rtemp;
    logic                        r_out_valid;
    logic [TEMP_BITS-1:0]        r_out_ftemp;
    logic [TEMP_BITS-1:0]        r_out_rtemp;
    logic [LEVEL_BITS-1:0]       r_out_level;

    logic                        in_accept;
    logic                        out_free;
    logic [LEVEL_BITS-1:0]       in_level;
    logic [LEVEL_BITS-1:0]       cur_level;
    t_coef                       coef;
    logic signed [OPA_BITS-1:0]  op_a;
    logic signed [OPB_BITS-1:0]  op_b;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [OPB_BITS-1:0]  lin_term;
    logic signed [HI_BITS-1:0]   prod_hi;
    logic signed [HI_BITS:0]     upd_sum;
    logic signed [CURVE_BITS-1:0] curve_t;
    logic [TEMP_BITS-1:0]        curve_temp;
    logic                        load_out;
    logic                        out_off_curve;
    logic                        out_held;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_level   = i_adc_sample[SAMPLE_BITS-1:PRESCALE_SHIFT];
    assign cur_level  = r_sel_raw ? r_level : r_y[STATE_BITS-1:FRACTION_BITS];

    nss_curve_seg u_seg (
        .i_level (cur_level),
        .o_coef  (coef)
    );

    nss_mult u_mult (
        .i_clk  (i_clk),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (prod)
    );

    // y' = x + ((alpha * (y - x)) >>> 16), exact form of the convex mix
    assign prod_hi = prod[PROD_BITS-1:ALPHA_BITS];
    assign upd_sum = (HI_BITS+1)'($signed({1'b0, r_level, FRACTION_BITS'(0)}))
                   + (HI_BITS+1)'(prod_hi);

    assign lin_term = prod[OPB_BITS-1:0] - $signed({2'b00, coef.slope});
    assign curve_t  = prod[CURVE_BITS-1:0] + $signed({2'b00, coef.offs});

    always_comb begin
        if (!coef.on_curve || curve_t[CURVE_BITS-1]) begin
            curve_temp = '0;
        end else if (|curve_t[CURVE_BITS-2:CURVE_FRAC+TEMP_BITS]) begin
            curve_temp = '1;
        end else begin
            curve_temp = curve_t[CURVE_FRAC+TEMP_BITS-1:CURVE_FRAC];
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            S_FILT: begin
                op_a = r_diff;
                op_b = $signed({2'b00, r_alpha});
            end
            S_MUL1: begin
                op_a = $signed({(OPA_BITS-LEVEL_BITS)'(0), cur_level});
                op_b = coef.sq;
            end
            S_MUL2: begin
                op_a = OPA_BITS'(lin_term);
                op_b = $signed({(OPB_BITS-LEVEL_BITS)'(0), cur_level});
            end
            S_IDLE, S_UPD, S_ADD, S_DONE: begin
                op_a = '0;
                op_b = '0;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_accept) n_state = S_FILT;
            S_FILT: n_state = S_UPD;
            S_UPD:  n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_ADD;
            S_ADD:  n_state = r_sel_raw ? S_DONE : S_MUL1;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel_raw   <= 1'b0;
            r_alpha     <= ALPHA_RESET;
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_alpha <= i_cfg_data;
            end
            if (r_state == S_UPD) begin
                r_y       <= upd_sum[STATE_BITS-1:0];
                r_sel_raw <= 1'b0;
            end
            if (r_state == S_ADD) begin
                r_sel_raw <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_level <= in_level;
            r_diff  <= $signed({1'b0, r_y})
                     - $signed({1'b0, in_level, FRACTION_BITS'(0)});
        end
        if (r_state == S_ADD) begin
            if (r_sel_raw) begin
                r_rtemp <= curve_temp;
            end else begin
                r_ftemp <= curve_temp;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_ftemp <= r_ftemp;
            r_out_rtemp <= r_rtemp;
            r_out_level <= r_y[STATE_BITS-1:FRACTION_BITS];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_temp  = r_out_ftemp;
    assign o_raw_temp       = r_out_rtemp;
    assign o_filtered_level = r_out_level;

    assign load_out      = (r_state == S_DONE) && out_free;
    assign out_off_curve = o_out_valid
                         && ((o_filtered_level < CURVE_BOTTOM) || (o_filtered_level > CURVE_TOP));
    assign out_held      = o_out_valid && i_out_stall;

    `NSS_ASSERT_NEXT(a_accept_starts, in_accept, r_state == S_FILT, "item not started")
    `NSS_ASSERT_NEXT(a_done_loads, load_out, o_out_valid && (r_state == S_IDLE), "no result")
    `NSS_ASSERT_NOW(a_off_curve_zero, out_off_curve, o_filtered_temp == '0, "off-curve temp")
    `NSS_ASSERT_NEXT(a_stall_holds, out_held, o_out_valid && $stable(o_filtered_level), "held")

endmodule

FILE: verif/testbench.sv
// self-checking testbench for ntc_sample_smoother: random and directed converter readings
// with random input gaps and random output stalls, checked against an in-bench filter and curve model
// depends on nss_pkg and the rtl of ntc_sample_smoother
module testbench;
    import nss_pkg::*;

    localparam int SHIFT          = 3;
    localparam int FRAC           = 16;
    localparam int SETTLE_CYCLES  = 14;
    localparam int TAIL_CYCLES    = 30;
    localparam int LONG_HOLD      = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_ITEMS    = 104;
    localparam logic [ALPHA_BITS-1:0] ALPHA_AT_RESET = 16'd64225;

    // curve segment bounds and q.16 coefficients
    localparam longint LVL_TOP = 498, LVL_B20 = 476, LVL_B40 = 435;
    localparam longint LVL_B60 = 371, LVL_B100 = 208, LVL_BOTTOM = 76;
    localparam longint S1_SLOPE = 59054, S1_OFFS = 29482025;
    localparam longint S2_SLOPE = 31674, S2_OFFS = 16458711;
    localparam longint S3_SLOPE = 20165, S3_OFFS = 11441930;
    localparam longint S4_SLOPE = 15820, S4_OFFS = 9816637;
    localparam longint Q_SQ = 79, Q_SLOPE = 45954, Q_OFFS = 12814909;

    typedef enum logic [1:0] {JOB_SAMPLE, JOB_ALPHA, JOB_DRAIN, JOB_HOLD} job_kind_e;

    typedef struct {
        job_kind_e   kind;
        int unsigned value;
    } job_t;

    typedef struct packed {
        logic [TEMP_BITS-1:0]  filtered_temp;
        logic [TEMP_BITS-1:0]  raw_temp;
        logic [LEVEL_BITS-1:0] filtered_level;
    } reading_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [ALPHA_BITS-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [SAMPLE_BITS-1:0] i_adc_sample = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [TEMP_BITS-1:0]   o_filtered_temp;
    logic [TEMP_BITS-1:0]   o_raw_temp;
    logic [LEVEL_BITS-1:0]  o_filtered_level;

    ntc_sample_smoother dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_adc_sample    (i_adc_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_filtered_temp (o_filtered_temp),
        .o_raw_temp      (o_raw_temp),
        .o_filtered_level(o_filtered_level)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [ALPHA_BITS-1:0]        alpha_q = ALPHA_AT_RESET;
    logic [LEVEL_BITS+FRAC-1:0]   level_q = '0;

    job_t       work_q[$];
    reading_t   readings_due[$];
    int         fault_count = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    logic       hold_req = 1'b0;

    function automatic logic [TEMP_BITS-1:0] ntc_degrees(input logic [LEVEL_BITS-1:0] lvl);
        longint l;
        longint t;
        l = longint'(lvl);
        if (l < LVL_BOTTOM || l > LVL_TOP) return '0;
        if (l >= LVL_B20)       t = S1_OFFS - S1_SLOPE * l;
        else if (l >= LVL_B40)  t = S2_OFFS - S2_SLOPE * l;
        else if (l >= LVL_B60)  t = S3_OFFS - S3_SLOPE * l;
        else if (l >= LVL_B100) t = S4_OFFS - S4_SLOPE * l;
        else                    t = Q_SQ * l * l - Q_SLOPE * l + Q_OFFS;
        if (t < 0) return '0;
        t = t / 65536;
        if (t > 255) return 8'hFF;
        return t[TEMP_BITS-1:0];
    endfunction

    // advances the low-pass by one reading and queues the expected outputs
    function void smooth_and_linearize(input logic [SAMPLE_BITS-1:0] sample);
        logic [LEVEL_BITS-1:0] lvl;
        logic [63:0]           mix;
        reading_t              r;
        lvl = LEVEL_BITS'(sample >> SHIFT);
        mix = (64'd65536 - alpha_q) * (64'(lvl) << FRAC) + 64'(alpha_q) * 64'(level_q);
        level_q = mix[FRAC +: LEVEL_BITS+FRAC];
        r.filtered_level = level_q[FRAC +: LEVEL_BITS];
        r.filtered_temp  = ntc_degrees(r.filtered_level);
        r.raw_temp       = ntc_degrees(lvl);
        readings_due.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int unsigned pick_sample();
        int          r;
        int unsigned lv;
        int unsigned edges[12] = '{75, 76, 207, 208, 370, 371, 434, 435, 475, 476, 498, 499};
        r = $urandom_range(0, 99);
        if (r < 35) return $urandom_range(0, 4095);
        if (r < 75) return $urandom_range(608, 3999);
        lv = edges[$urandom_range(0, 11)] + $urandom_range(0, 2) - 1;
        return (lv << SHIFT) | $urandom_range(0, 7);
    endfunction

    function void add_job(input job_kind_e kind, input int unsigned value);
        job_t j;
        j.kind  = kind;
        j.value = value;
        work_q.push_back(j);
    endfunction

    task report_fault(input string msg);
        if (fault_count < 10) $display("%0t: %s", $realtime, msg);
        fault_count++;
    endtask

    // driver
    logic                   drv_valid = 1'b0;
    logic [SAMPLE_BITS-1:0] drv_sample = '0;
    logic                   drv_we = 1'b0;
    logic [ALPHA_BITS-1:0]  drv_cfg = '0;
    logic                   drv_hold = 1'b0;
    int                     gap_left = 0;
    int                     quiet_cycles = 0;
    job_t                   job;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid    = 1'b0;
            drv_we       = 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
        end else begin
            drv_we = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                smooth_and_linearize(i_adc_sample);
                items_sent++;
                drv_valid = 1'b0;
            end
            // results_seen is the pre-edge count, so this is race free
            if (!drv_valid && items_sent == results_seen) quiet_cycles++;
            else quiet_cycles = 0;
            if (!drv_valid && work_q.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    job = work_q[0];
                    case (job.kind)
                        JOB_SAMPLE: begin
                            drv_valid  = 1'b1;
                            drv_sample = SAMPLE_BITS'(job.value);
                            gap_left   = pick_gap();
                            void'(work_q.pop_front());
                        end
                        JOB_ALPHA: begin
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                drv_we  = 1'b1;
                                drv_cfg = ALPHA_BITS'(job.value);
                                alpha_q = drv_cfg;
                                void'(work_q.pop_front());
                            end
                        end
                        JOB_DRAIN: begin
                            if (quiet_cycles >= SETTLE_CYCLES) void'(work_q.pop_front());
                        end
                        JOB_HOLD: begin
                            drv_hold = 1'b1;
                            void'(work_q.pop_front());
                        end
                        default: void'(work_q.pop_front());
                    endcase
                end
            end
        end
        i_in_valid   <= drv_valid;
        i_adc_sample <= drv_sample;
        i_cfg_we     <= drv_we;
        i_cfg_data   <= drv_cfg;
        hold_req     <= drv_hold;
    end

    // receiver stall pattern, plus one long hold-off on request
    logic stall_now = 1'b0;
    int   stall_run = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_now = 1'b0;
            stall_run = 0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            stall_now = 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
            stall_now = 1'b1;
        end else if (stall_run != 0) begin
            stall_run--;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    stall_now = 1'b0;
                    stall_run = $urandom_range(0, 20);
                end
                5, 6, 7, 8: begin
                    stall_now = 1'b1;
                    stall_run = $urandom_range(0, 2);
                end
                default: begin
                    stall_now = 1'b1;
                    stall_run = $urandom_range(10, 40);
                end
            endcase
        end
        i_out_stall <= stall_now;
    end

    // monitor
    reading_t want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (readings_due.size() == 0) begin
                report_fault($sformatf("unexpected item: ftemp %0d rtemp %0d flevel %0d",
                    o_filtered_temp, o_raw_temp, o_filtered_level));
            end else begin
                want = readings_due.pop_front();
                if (o_filtered_temp !== want.filtered_temp || o_raw_temp !== want.raw_temp
                        || o_filtered_level !== want.filtered_level) begin
                    report_fault($sformatf(
                        "mismatch: ftemp %0d/%0d rtemp %0d/%0d flevel %0d/%0d (exp/got)",
                        want.filtered_temp, o_filtered_temp, want.raw_temp, o_raw_temp,
                        want.filtered_level, o_filtered_level));
                end
            end
        end
    end

    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned edge_levels[12];
        int unsigned phase_alpha[7];

        edge_levels = '{75, 76, 207, 208, 370, 371, 434, 435, 475, 476, 498, 499};

        // directed: field extremes and mid-scale under the reset weight
        add_job(JOB_SAMPLE, 0);
        add_job(JOB_SAMPLE, 4095);
        add_job(JOB_SAMPLE, 2048);
        // zero weight makes the filtered level follow the input, so both curves
        // see every segment boundary and both off-curve sides
        add_job(JOB_ALPHA, 0);
        foreach (edge_levels[k])
            add_job(JOB_SAMPLE, (edge_levels[k] << SHIFT) | ((k % 2 == 1) ? 7 : 0));
        add_job(JOB_SAMPLE, 150 << SHIFT);
        add_job(JOB_SAMPLE, 4095);
        add_job(JOB_SAMPLE, 0);
        // full weight: filter barely moves
        add_job(JOB_ALPHA, 65535);
        add_job(JOB_SAMPLE, 4095);
        add_job(JOB_SAMPLE, 4095);
        add_job(JOB_SAMPLE, 0);

        phase_alpha = '{64225, 32768, 1, $urandom_range(60000, 65535),
                        $urandom_range(0, 65535), 65535, $urandom_range(0, 65535)};
        foreach (phase_alpha[p]) begin
            add_job(JOB_ALPHA, phase_alpha[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == 20) add_job(JOB_HOLD, 0);
                if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1) add_job(JOB_DRAIN, 0);
                add_job(JOB_SAMPLE, pick_sample());
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (work_q.size() != 0 || i_in_valid || items_sent != results_seen)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/nss_pkg.sv
rtl/nss_mult.sv
rtl/nss_curve_seg.sv
rtl/ntc_sample_smoother.sv
verif/testbench.sv
